// ===== src/assert_macros.svh =====
// Assertion macros shared by the stereo biquad filter sources.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define SBQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on i_clk and disabled while i_rst_n is low.
`define SBQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/sbq_pkg.sv =====
// Shared types and constants of the stereo biquad filter.
package sbq_pkg;

    // Default sizes of the top level parameters.
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 22;

    // Accumulator width; sums wrap at this width.
    localparam int ACC_WIDTH = 64;

    // Configuration port geometry.
    localparam int PADDR_WIDTH = 5;
    localparam int PDATA_WIDTH = 32;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_B0   = 3'd0,
        REG_B1   = 3'd1,
        REG_B2   = 3'd2,
        REG_A1   = 3'd3,
        REG_A2   = 3'd4,
        REG_GAIN = 3'd5
    } t_reg_idx;

    // Steps of the per-frame sequence.
    localparam int STEP_WIDTH = 4;
    localparam logic [STEP_WIDTH-1:0] STEP_B0     = 4'd0;
    localparam logic [STEP_WIDTH-1:0] STEP_B1     = 4'd1;
    localparam logic [STEP_WIDTH-1:0] STEP_B2     = 4'd2;
    localparam logic [STEP_WIDTH-1:0] STEP_A1     = 4'd3;
    localparam logic [STEP_WIDTH-1:0] STEP_A2     = 4'd4;
    localparam logic [STEP_WIDTH-1:0] STEP_ACC    = 4'd5;
    localparam logic [STEP_WIDTH-1:0] STEP_COMMIT = 4'd6;
    localparam logic [STEP_WIDTH-1:0] STEP_GAIN   = 4'd7;
    localparam logic [STEP_WIDTH-1:0] STEP_OUT    = 4'd8;

    // Multiplier operand selection.
    typedef enum logic [2:0] {
        MUL_B0   = 3'd0,
        MUL_B1   = 3'd1,
        MUL_B2   = 3'd2,
        MUL_A1   = 3'd3,
        MUL_A2   = 3'd4,
        MUL_GAIN = 3'd5
    } t_mul_sel;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } t_acc_op;

    // Control word sent from the sequencer to every lane.
    typedef struct packed {
        logic     load_x;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     commit;
    } t_lane_ctrl;

endpackage

// ===== src/sbq_lane.sv =====
// One channel of the biquad: delay line, shared multiplier, accumulator and rounding.
module sbq_lane #(
    parameter int SAMPLE_WIDTH   = sbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbq_pkg::t_lane_ctrl         i_ctrl,
    input  logic [SAMPLE_WIDTH-1:0]     i_sample,
    input  logic [COEF_FRAC_BITS+1:0]   i_coef_b0,
    input  logic [COEF_FRAC_BITS+1:0]   i_coef_b1,
    input  logic [COEF_FRAC_BITS+1:0]   i_coef_b2,
    input  logic [COEF_FRAC_BITS+1:0]   i_coef_a1,
    input  logic [COEF_FRAC_BITS+1:0]   i_coef_a2,
    input  logic [COEF_FRAC_BITS:0]     i_gain,
    output logic [SAMPLE_WIDTH-1:0]     o_result
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int AW = sbq_pkg::ACC_WIDTH;
    localparam logic [AW-1:0] RND_HALF = AW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [SW-1:0] SAT_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAT_MIN  = {1'b1, {(SW-1){1'b0}}};

    // Round to nearest (ties up), drop the fraction, saturate to a sample.
    function automatic logic [SW-1:0] round_sat(input logic [AW-1:0] v);
        logic [AW-1:0]        s;
        logic signed [AW-1:0] q;
        logic [SW-1:0]        res;
        s = v + RND_HALF;
        q = $signed(s) >>> COEF_FRAC_BITS;
        if ((&q[AW-1:SW-1]) || !(|q[AW-1:SW-1])) begin
            res = q[SW-1:0];
        end else if (q[AW-1]) begin
            res = SAT_MIN;
        end else begin
            res = SAT_MAX;
        end
        return res;
    endfunction

    logic [SW-1:0] r_x;
    logic [SW-1:0] r_xd1;
    logic [SW-1:0] r_xd2;
    logic [SW-1:0] r_yd1;
    logic [SW-1:0] r_yd2;
    logic [AW-1:0] r_prod;
    logic [AW-1:0] r_acc;

    logic signed [CW-1:0]    mul_a;
    logic signed [SW-1:0]    mul_b;
    logic signed [CW+SW-1:0] mul_p;

    // Operand selection for the single multiplier of this lane.
    always_comb begin
        unique case (i_ctrl.mul_sel)
            sbq_pkg::MUL_B0: begin
                mul_a = $signed(i_coef_b0);
                mul_b = $signed(r_x);
            end
            sbq_pkg::MUL_B1: begin
                mul_a = $signed(i_coef_b1);
                mul_b = $signed(r_xd1);
            end
            sbq_pkg::MUL_B2: begin
                mul_a = $signed(i_coef_b2);
                mul_b = $signed(r_xd2);
            end
            sbq_pkg::MUL_A1: begin
                mul_a = $signed(i_coef_a1);
                mul_b = $signed(r_yd1);
            end
            sbq_pkg::MUL_A2: begin
                mul_a = $signed(i_coef_a2);
                mul_b = $signed(r_yd2);
            end
            sbq_pkg::MUL_GAIN: begin
                mul_a = $signed({1'b0, i_gain});
                mul_b = $signed(r_yd1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Input sample and registered product.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_x) begin
            r_x <= i_sample;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= AW'(mul_p);
        end
    end

    // Accumulator of the five weighted terms.
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.acc_op)
            sbq_pkg::ACC_LOAD: r_acc <= r_prod;
            sbq_pkg::ACC_ADD:  r_acc <= r_acc + r_prod;
            sbq_pkg::ACC_SUB:  r_acc <= r_acc - r_prod;
            default:           r_acc <= r_acc;
        endcase
    end

    // Filter history; the saturated output becomes the newest feedback term.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xd1 <= '0;
            r_xd2 <= '0;
            r_yd1 <= '0;
            r_yd2 <= '0;
        end else if (i_ctrl.commit) begin
            r_xd2 <= r_xd1;
            r_xd1 <= r_x;
            r_yd2 <= r_yd1;
            r_yd1 <= round_sat(r_acc);
        end
    end

    // Gain-scaled output of this channel.
    assign o_result = round_sat(r_prod);

endmodule

// ===== src/stereo_biquad_filter.sv =====
// Stereo biquad filter top level: configuration, sequencer, two lanes and output register.
// Sequence per frame: nine steps on each lane's single multiplier (five taps, last subtract,
// rounding, gain, output), then the result word goes to the output register; a stalled output
// waits. A new frame is taken only after the previous result word is in the output register.
// Reset (synchronous, active low) clears the filter history, the sequencer and the output
// valid, and loads b0 and the gain with 1.0 and the other coefficients with 0.
module stereo_biquad_filter #(
    parameter int SAMPLE_WIDTH   = sbq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF,
    localparam int TDATA_WIDTH   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB configuration port
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [sbq_pkg::PADDR_WIDTH-1:0] i_paddr,
    input  logic [sbq_pkg::PDATA_WIDTH-1:0] i_pwdata,
    output logic [sbq_pkg::PDATA_WIDTH-1:0] o_prdata,
    output logic                            o_pready,
    // Input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [TDATA_WIDTH-1:0]          i_s_axis_tdata,  // sample_left, sample_right
    input  logic                            i_s_axis_tlast,  // end_of_buffer
    // Output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [TDATA_WIDTH-1:0]          o_m_axis_tdata,  // out_left, out_right
    output logic                            o_m_axis_tlast   // out_last
);

    `include "assert_macros.svh"

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int GW = COEF_FRAC_BITS + 1;
    localparam int DW = sbq_pkg::PDATA_WIDTH;
    localparam logic [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;
    localparam logic [GW-1:0] GAIN_ONE = GW'(1) << COEF_FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    logic [CW-1:0] r_coef_b0;
    logic [CW-1:0] r_coef_b1;
    logic [CW-1:0] r_coef_b2;
    logic [CW-1:0] r_coef_a1;
    logic [CW-1:0] r_coef_a2;
    logic [GW-1:0] r_gain;

    t_state                           r_state;
    t_state                           n_state;
    logic [sbq_pkg::STEP_WIDTH-1:0]   r_cnt;
    logic [sbq_pkg::STEP_WIDTH-1:0]   n_cnt;
    logic                             r_last;
    logic                             r_out_valid;
    logic [SW-1:0]                    r_out_left;
    logic [SW-1:0]                    r_out_right;
    logic                             r_out_last;

    sbq_pkg::t_lane_ctrl lane_ctrl;
    sbq_pkg::t_reg_idx   reg_idx;
    logic                cfg_write;
    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic [SW-1:0]       res_left;
    logic [SW-1:0]       res_right;

    // Configuration registers.
    assign reg_idx   = sbq_pkg::t_reg_idx'(i_paddr[4:2]);
    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0 <= COEF_ONE;
            r_coef_b1 <= '0;
            r_coef_b2 <= '0;
            r_coef_a1 <= '0;
            r_coef_a2 <= '0;
            r_gain    <= GAIN_ONE;
        end else if (cfg_write) begin
            unique case (reg_idx)
                sbq_pkg::REG_B0:   r_coef_b0 <= i_pwdata[CW-1:0];
                sbq_pkg::REG_B1:   r_coef_b1 <= i_pwdata[CW-1:0];
                sbq_pkg::REG_B2:   r_coef_b2 <= i_pwdata[CW-1:0];
                sbq_pkg::REG_A1:   r_coef_a1 <= i_pwdata[CW-1:0];
                sbq_pkg::REG_A2:   r_coef_a2 <= i_pwdata[CW-1:0];
                sbq_pkg::REG_GAIN: r_gain    <= i_pwdata[GW-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            sbq_pkg::REG_B0:   o_prdata = DW'(r_coef_b0);
            sbq_pkg::REG_B1:   o_prdata = DW'(r_coef_b1);
            sbq_pkg::REG_B2:   o_prdata = DW'(r_coef_b2);
            sbq_pkg::REG_A1:   o_prdata = DW'(r_coef_a1);
            sbq_pkg::REG_A2:   o_prdata = DW'(r_coef_a2);
            sbq_pkg::REG_GAIN: o_prdata = DW'(r_gain);
            default:           o_prdata = '0;
        endcase
    end

    // Handshake terms.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign out_load        = out_free &&
                             ((r_state == S_CALC && r_cnt == sbq_pkg::STEP_OUT) ||
                              r_state == S_WAIT);

    // Sequencer state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_CALC;
                    n_cnt   = sbq_pkg::STEP_B0;
                end
            end
            S_CALC: begin
                if (r_cnt == sbq_pkg::STEP_OUT) begin
                    n_state = out_load ? S_IDLE : S_WAIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WAIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Control word for both lanes, decoded from the step count.
    always_comb begin
        lane_ctrl         = '0;
        lane_ctrl.mul_sel = sbq_pkg::MUL_B0;
        lane_ctrl.acc_op  = sbq_pkg::ACC_HOLD;
        lane_ctrl.load_x  = in_accept;
        if (r_state == S_CALC) begin
            unique case (r_cnt)
                sbq_pkg::STEP_B0: begin
                    lane_ctrl.mul_en  = 1'b1;
                    lane_ctrl.mul_sel = sbq_pkg::MUL_B0;
                end
                sbq_pkg::STEP_B1: begin
                    lane_ctrl.mul_en  = 1'b1;
                    lane_ctrl.mul_sel = sbq_pkg::MUL_B1;
                    lane_ctrl.acc_op  = sbq_pkg::ACC_LOAD;
                end
                sbq_pkg::STEP_B2: begin
                    lane_ctrl.mul_en  = 1'b1;
                    lane_ctrl.mul_sel = sbq_pkg::MUL_B2;
                    lane_ctrl.acc_op  = sbq_pkg::ACC_ADD;
                end
                sbq_pkg::STEP_A1: begin
                    lane_ctrl.mul_en  = 1'b1;
                    lane_ctrl.mul_sel = sbq_pkg::MUL_A1;
                    lane_ctrl.acc_op  = sbq_pkg::ACC_ADD;
                end
                sbq_pkg::STEP_A2: begin
                    lane_ctrl.mul_en  = 1'b1;
                    lane_ctrl.mul_sel = sbq_pkg::MUL_A2;
                    lane_ctrl.acc_op  = sbq_pkg::ACC_SUB;
                end
                sbq_pkg::STEP_ACC: begin
                    lane_ctrl.acc_op = sbq_pkg::ACC_SUB;
                end
                sbq_pkg::STEP_COMMIT: begin
                    lane_ctrl.commit = 1'b1;
                end
                sbq_pkg::STEP_GAIN: begin
                    lane_ctrl.mul_en  = 1'b1;
                    lane_ctrl.mul_sel = sbq_pkg::MUL_GAIN;
                end
                default: ;
            endcase
        end
    end

    // Left and right lanes share coefficients and control.
    sbq_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (lane_ctrl),
        .i_sample  (i_s_axis_tdata[SW-1:0]),
        .i_coef_b0 (r_coef_b0),
        .i_coef_b1 (r_coef_b1),
        .i_coef_b2 (r_coef_b2),
        .i_coef_a1 (r_coef_a1),
        .i_coef_a2 (r_coef_a2),
        .i_gain    (r_gain),
        .o_result  (res_left)
    );

    sbq_lane #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (lane_ctrl),
        .i_sample  (i_s_axis_tdata[2*SW-1:SW]),
        .i_coef_b0 (r_coef_b0),
        .i_coef_b1 (r_coef_b1),
        .i_coef_b2 (r_coef_b2),
        .i_coef_a1 (r_coef_a1),
        .i_coef_a2 (r_coef_a2),
        .i_gain    (r_gain),
        .o_result  (res_right)
    );

    // End-of-buffer flag travels with the frame.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_last <= i_s_axis_tlast;
        end
    end

    // Output register merges both lanes into one word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_left  <= res_left;
            r_out_right <= res_right;
            r_out_last  <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_WIDTH'({r_out_right, r_out_left});
    assign o_m_axis_tlast  = r_out_last;

    // A new result only appears at the end of a sequence.
    `SBQ_ASSERT_IMPL(a_out_from_seq, $rose(r_out_valid), $past(r_state) != S_IDLE)
    // A taken frame starts the sequence at its first step.
    `SBQ_ASSERT_NEXT(a_accept_starts, in_accept, (r_state == S_CALC && r_cnt == sbq_pkg::STEP_B0))
    // The step count never runs past the output step while computing.
    `SBQ_ASSERT_IMPL(a_cnt_bound, r_state == S_CALC, r_cnt <= sbq_pkg::STEP_OUT)

endmodule

// ===== dv/stereo_biquad_filter_tb.sv =====
// Self-checking testbench of the stereo biquad filter: streams frames, predicts each output word.
module stereo_biquad_filter_tb;

    localparam int SW          = sbq_pkg::SAMPLE_WIDTH_DEF;
    localparam int FRAC        = sbq_pkg::COEF_FRAC_BITS_DEF;
    localparam int COEF_W      = FRAC + 2;
    localparam int GAIN_W      = FRAC + 1;
    localparam int TDATA_W     = ((2 * SW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 20;
    localparam int RX_STALL    = 400;
    localparam int ROUND_ITEMS = 85;

    // Indexes past the last register; writes there must be ignored.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam logic [31:0] COEF_MAX = 32'h007F_FFFF;
    localparam logic [31:0] COEF_MIN = 32'hFF80_0000;
    localparam logic [31:0] UNITY    = 32'h0040_0000;
    localparam logic [31:0] GAIN_MAX = 32'h007F_FFFF;

    localparam longint SAT_HI = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef enum int {CFG_EXTREME, CFG_TYPICAL, CFG_RAW} t_cfg_style;

    // One stereo frame, input or filtered output.
    typedef struct packed {
        logic          last;
        logic [SW-1:0] right;
        logic [SW-1:0] left;
    } t_stereo_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_psel = 1'b0;
    logic                            i_penable = 1'b0;
    logic                            i_pwrite = 1'b0;
    logic [sbq_pkg::PADDR_WIDTH-1:0] i_paddr = '0;
    logic [sbq_pkg::PDATA_WIDTH-1:0] i_pwdata = '0;
    logic [sbq_pkg::PDATA_WIDTH-1:0] o_prdata;
    logic                            o_pready;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [TDATA_W-1:0]              i_s_axis_tdata = '0;  // sample_left, sample_right
    logic                            i_s_axis_tlast = 1'b0; // end_of_buffer
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]              o_m_axis_tdata;       // out_left, out_right
    logic                            o_m_axis_tlast;       // out_last

    stereo_biquad_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the coefficient registers.
    logic [COEF_W-1:0] coef_b0 = UNITY[COEF_W-1:0];
    logic [COEF_W-1:0] coef_b1 = '0;
    logic [COEF_W-1:0] coef_b2 = '0;
    logic [COEF_W-1:0] coef_a1 = '0;
    logic [COEF_W-1:0] coef_a2 = '0;
    logic [GAIN_W-1:0] gain_q  = UNITY[GAIN_W-1:0];

    // Filter history per channel: index 0 is left, 1 is right.
    longint x_d1[2];
    longint x_d2[2];
    longint y_d1[2];
    longint y_d2[2];

    t_stereo_word frame_q[$];
    t_stereo_word filtered_q[$];
    t_stereo_word cur_frame;
    t_stereo_word got_word;
    t_stereo_word want_word;

    int  err_cnt     = 0;
    int  cycle_cnt   = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_stall_go = 1'b0;
    logic rx_hold    = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    function automatic longint round_sat(input longint acc);
        longint v;
        v = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (v > SAT_HI) v = SAT_HI;
        if (v < SAT_LO) v = SAT_LO;
        return v;
    endfunction

    // One direct-form-1 step of one channel, gain applied after the stored output.
    function automatic logic [SW-1:0] filter_channel(input int ch, input logic [SW-1:0] xin);
        longint x;
        longint acc;
        longint y;
        x = longint'($signed(xin));
        acc = longint'($signed(coef_b0)) * x
            + longint'($signed(coef_b1)) * x_d1[ch]
            + longint'($signed(coef_b2)) * x_d2[ch]
            - longint'($signed(coef_a1)) * y_d1[ch]
            - longint'($signed(coef_a2)) * y_d2[ch];
        y = round_sat(acc);
        x_d2[ch] = x_d1[ch];
        x_d1[ch] = x;
        y_d2[ch] = y_d1[ch];
        y_d1[ch] = y;
        return SW'(round_sat(y * longint'({1'b0, gain_q})));
    endfunction

    function automatic t_stereo_word filter_frame(input t_stereo_word f);
        t_stereo_word r;
        r.left  = filter_channel(0, f.left);
        r.right = filter_channel(1, f.right);
        r.last  = f.last;
        return r;
    endfunction

    function automatic logic [SW-1:0] random_sample();
        logic signed [SW-1:0] s;
        s = SW'($urandom);
        if ($urandom_range(3) != 0) s = s >>> $urandom_range(14);
        return s;
    endfunction

    task automatic push_frame(input logic [SW-1:0] l, input logic [SW-1:0] r, input logic last);
        t_stereo_word f;
        f.left  = l;
        f.right = r;
        f.last  = last;
        frame_q.push_back(f);
    endtask

    // APB write: setup cycle, access cycle, then the shadow register follows.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        case (idx)
            sbq_pkg::REG_B0:   coef_b0 = data[COEF_W-1:0];
            sbq_pkg::REG_B1:   coef_b1 = data[COEF_W-1:0];
            sbq_pkg::REG_B2:   coef_b2 = data[COEF_W-1:0];
            sbq_pkg::REG_A1:   coef_a1 = data[COEF_W-1:0];
            sbq_pkg::REG_A2:   coef_a2 = data[COEF_W-1:0];
            sbq_pkg::REG_GAIN: gain_q  = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_extreme();
        return $urandom_range(1) ? COEF_MAX : COEF_MIN;
    endfunction

    function automatic logic [31:0] signed_span(input int half);
        return 32'(int'($urandom_range(2 * half)) - half);
    endfunction

    task automatic apply_config(input t_cfg_style style);
        case (style)
            CFG_EXTREME: begin
                write_reg(sbq_pkg::REG_B0, pick_extreme());
                write_reg(sbq_pkg::REG_B1, pick_extreme());
                write_reg(sbq_pkg::REG_B2, pick_extreme());
                write_reg(sbq_pkg::REG_A1, pick_extreme());
                write_reg(sbq_pkg::REG_A2, pick_extreme());
                write_reg(sbq_pkg::REG_GAIN, $urandom_range(1) ? GAIN_MAX : 32'd0);
            end
            CFG_TYPICAL: begin
                // Low-order filters with feedback near the usual stable region.
                write_reg(sbq_pkg::REG_B0, signed_span(2097152));
                write_reg(sbq_pkg::REG_B1, signed_span(4194304));
                write_reg(sbq_pkg::REG_B2, signed_span(2097152));
                write_reg(sbq_pkg::REG_A1, 32'(-int'($urandom_range(8000000))));
                write_reg(sbq_pkg::REG_A2, 32'($urandom_range(4000000)));
                write_reg(sbq_pkg::REG_GAIN, 32'($urandom_range(6000000, 2097152)));
            end
            default: begin
                // Raw words: the upper bits beyond each register must be dropped.
                write_reg(sbq_pkg::REG_B0, $urandom);
                write_reg(sbq_pkg::REG_B1, $urandom);
                write_reg(sbq_pkg::REG_B2, $urandom);
                write_reg(sbq_pkg::REG_A1, $urandom);
                write_reg(sbq_pkg::REG_A2, $urandom);
                write_reg(sbq_pkg::REG_GAIN, $urandom);
            end
        endcase
        if ($urandom_range(1)) write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    endtask

    // Wait until every frame went in and every word came out.
    task automatic drain();
        while (frame_q.size() != 0 || i_s_axis_tvalid || filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Input driver: takes frames from the pending queue, predicts each accepted word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                filtered_q.push_back(filter_frame(cur_frame));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (frame_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_frame = frame_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {cur_frame.right, cur_frame.left};
                    i_s_axis_tlast  <= cur_frame.last;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compares each accepted word with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_word.left  = o_m_axis_tdata[SW-1:0];
                got_word.right = o_m_axis_tdata[2*SW-1:SW];
                got_word.last  = o_m_axis_tlast;
                if (filtered_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", got_word));
                end else begin
                    want_word = filtered_q.pop_front();
                    if (got_word.left !== want_word.left)
                        report_mismatch($sformatf("out_left got %h expected %h",
                                                  got_word.left, want_word.left));
                    if (got_word.right !== want_word.right)
                        report_mismatch($sformatf("out_right got %h expected %h",
                                                  got_word.right, want_word.right));
                    if (got_word.last !== want_word.last)
                        report_mismatch($sformatf("out_last got %b expected %b",
                                                  got_word.last, want_word.last));
                end
            end
            i_m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver stall so the block fills up and pushes back on its input.
    initial begin
        wait (rx_stall_go);
        rx_hold <= 1'b1;
        repeat (RX_STALL) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Watchdog.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        for (int c = 0; c < 2; c++) begin
            x_d1[c] = 0;
            x_d2[c] = 0;
            y_d1[c] = 0;
            y_d2[c] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset coefficients pass samples through unchanged, extremes included.
        push_frame('0, '0, 1'b0);
        push_frame(COEF_MAX[SW-1:0], COEF_MIN[SW-1:0], 1'b1);
        push_frame(COEF_MIN[SW-1:0], COEF_MAX[SW-1:0], 1'b0);
        push_frame('1, SW'(1), 1'b0);
        push_frame(SW'(1), '1, 1'b1);
        push_frame(COEF_MAX[SW-1:0], COEF_MAX[SW-1:0], 1'b0);
        push_frame(COEF_MIN[SW-1:0], COEF_MIN[SW-1:0], 1'b1);
        drain();

        // Largest coefficients and largest gain: the output saturates hard.
        write_reg(sbq_pkg::REG_B0, COEF_MAX);
        write_reg(sbq_pkg::REG_B1, COEF_MIN);
        write_reg(sbq_pkg::REG_B2, COEF_MAX);
        write_reg(sbq_pkg::REG_A1, COEF_MIN);
        write_reg(sbq_pkg::REG_A2, COEF_MAX);
        write_reg(sbq_pkg::REG_GAIN, GAIN_MAX);
        push_frame(COEF_MAX[SW-1:0], COEF_MIN[SW-1:0], 1'b0);
        push_frame('0, '0, 1'b0);
        push_frame(COEF_MIN[SW-1:0], COEF_MAX[SW-1:0], 1'b1);
        push_frame(SW'(1), '1, 1'b0);
        push_frame('0, '0, 1'b1);
        drain();

        // Opposite extremes with zero gain: every output is zero.
        write_reg(sbq_pkg::REG_B0, COEF_MIN);
        write_reg(sbq_pkg::REG_B1, COEF_MAX);
        write_reg(sbq_pkg::REG_B2, COEF_MIN);
        write_reg(sbq_pkg::REG_A1, COEF_MAX);
        write_reg(sbq_pkg::REG_A2, COEF_MIN);
        write_reg(sbq_pkg::REG_GAIN, 32'd0);
        push_frame(COEF_MAX[SW-1:0], COEF_MIN[SW-1:0], 1'b1);
        push_frame(COEF_MIN[SW-1:0], COEF_MAX[SW-1:0], 1'b0);
        push_frame('1, SW'(1), 1'b0);
        push_frame('0, '0, 1'b1);
        drain();

        // Writes past the last register change nothing; gain above unity.
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        write_reg(sbq_pkg::REG_B0, UNITY);
        write_reg(sbq_pkg::REG_B1, 32'd1048576);
        write_reg(sbq_pkg::REG_B2, 32'(-1048576));
        write_reg(sbq_pkg::REG_A1, 32'(-2097152));
        write_reg(sbq_pkg::REG_A2, 32'd1048576);
        write_reg(sbq_pkg::REG_GAIN, 32'd6000000);
        push_frame(COEF_MAX[SW-1:0], COEF_MIN[SW-1:0], 1'b0);
        push_frame(SW'(4000000), SW'(-4000000), 1'b0);
        push_frame('0, '0, 1'b1);
        push_frame(SW'(12345), SW'(-777), 1'b0);
        drain();

        // Random part: receiver-heavy idling, then sender-heavy, then none.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 87 : 0;
            rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 27 : 0;
            for (int round = 0; round < 2; round++) begin
                apply_config(t_cfg_style'($urandom_range(2)));
                for (int n = 0; n < ROUND_ITEMS; n++)
                    push_frame(random_sample(), random_sample(), $urandom_range(7) == 0);
                if (phase == 2 && round == 0) rx_stall_go = 1'b1;
                drain();
            end
        end

        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sbq_pkg.sv
src/sbq_lane.sv
src/stereo_biquad_filter.sv
dv/stereo_biquad_filter_tb.sv
